// ===== rtl/core/kwm_pkg.sv =====
`default_nettype none

package kwm_pkg;

    // Default sizes of the merge unit
    localparam int LANES_DEF      = 8;
    localparam int LANE_DEPTH_DEF = 8;

    // Fixed field widths of the channels
    localparam int LANE_FW  = 3;
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 4;
    localparam int CFG_RESET = 8;

    // Request kinds
    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept_cfg;
        logic accept_in;
        logic scan_start;
        logic scan_step;
        logic emit;
        logic mark;
    } kwm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic drop;
        logic complete_on_end;
        logic can_emit;
        logic scan_last;
        logic out_free;
    } kwm_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/kwm_if.sv =====
`default_nettype none

// Input request channel
interface kwm_in_if;
    import kwm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [LANE_FW-1:0]        lane;
    logic signed [VALUE_W-1:0] value;
    modport source (output valid, kind, lane, value, input ready);
    modport sink (input valid, kind, lane, value, output ready);
endinterface

// Merged result channel
interface kwm_out_if;
    import kwm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] merged_value;
    logic [LANE_FW-1:0]        source_lane;
    logic                      has_value;
    logic                      last;
    logic                      dropped;
    modport source (output valid, merged_value, source_lane, has_value, last, dropped,
                    input ready);
    modport sink (input valid, merged_value, source_lane, has_value, last, dropped,
                  output ready);
endinterface

// Configuration write channel
interface kwm_cfg_if;
    import kwm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] lanes_in_use;
    modport source (output valid, lanes_in_use, input ready);
    modport sink (input valid, lanes_in_use, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kwm_ctrl.sv =====
`default_nettype none

module kwm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                cfg_valid,
    input  wire kwm_pkg::kwm_status_t status,
    output logic                     in_ready,
    output logic                     cfg_ready,
    output kwm_pkg::kwm_cmd_t        cmd
);
    import kwm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_MARK
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take requests and configuration only while idle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.accept_cfg = cfg_valid && cfg_ready;
        cmd.accept_in  = in_valid && in_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept_in)
                begin
                    if (status.drop || status.complete_on_end)
                        state_next = ST_MARK;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.can_emit)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_MARK:
            begin
                if (status.out_free)
                begin
                    cmd.mark   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/kwm_datapath.sv =====
`default_nettype none

module kwm_datapath #(
    parameter int LANES      = kwm_pkg::LANES_DEF,
    parameter int LANE_DEPTH = kwm_pkg::LANE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire kwm_pkg::kwm_cmd_t                   cmd,
    output kwm_pkg::kwm_status_t                     status,
    input  wire logic [kwm_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                in_kind,
    input  wire logic [kwm_pkg::LANE_FW-1:0]         in_lane,
    input  wire logic signed [kwm_pkg::VALUE_W-1:0]  in_value,
    kwm_out_if.source                                results
);
    import kwm_pkg::*;

    localparam int LANE_W    = $clog2(LANES);
    localparam int SLOT_W    = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LANE_DEPTH + 1);
    localparam int ENTRIES   = LANES * LANE_DEPTH;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int NUM_W     = $clog2(LANES + 1);
    localparam int CMP_W     = (NUM_W > LANE_FW) ? NUM_W : LANE_FW;
    localparam int CFG_CMP_W = (NUM_W > CFG_W) ? NUM_W : CFG_W;
    localparam int SUM_W     = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
    localparam int N_RESET   = (CFG_RESET > LANES) ? LANES : CFG_RESET;

    // Lane state
    logic [CNT_W-1:0]  cnt_reg [LANES];
    logic [SLOT_W-1:0] rd_reg [LANES];
    logic [LANES-1:0]  ended_reg;
    logic [NUM_W-1:0]  n_reg;
    logic [NUM_W-1:0]  n_next;

    // Lane store
    logic [VALUE_W-1:0] store_mem [ENTRIES];
    logic signed [VALUE_W-1:0] rd_data_reg;

    // Scan and best head
    logic [LANE_W-1:0]         scan_idx_reg;
    logic                      tag_valid_reg;
    logic [LANE_W-1:0]         tag_lane_reg;
    logic                      best_any_reg;
    logic [LANE_W-1:0]         best_lane_reg;
    logic signed [VALUE_W-1:0] best_val_reg;

    // Pending marker and output register
    logic                      pend_drop_reg;
    logic [LANE_FW-1:0]        pend_lane_reg;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [LANE_FW-1:0]        out_lane_reg;
    logic                      out_has_reg;
    logic                      out_last_reg;
    logic                      out_drop_reg;

    logic [LANES-1:0]  active;
    logic [LANES-1:0]  cnt_nz;
    logic [LANES-1:0]  end_done;
    logic [LANES-1:0]  pop_done;
    logic [LANE_W-1:0] in_idx;
    logic              in_act;
    logic              end_ok;
    logic              value_ok;
    logic              pop_completes;
    logic              clear_all;
    logic              all_ready;
    logic              any_head;
    logic [SUM_W-1:0]  wr_sum;
    logic [SLOT_W-1:0] wr_slot;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    assign in_idx = LANE_W'(in_lane);
    assign in_act = CMP_W'(in_lane) < CMP_W'(n_reg);

    // Per-lane flags
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            active[i]   = NUM_W'(i) < n_reg;
            cnt_nz[i]   = cnt_reg[i] != '0;
            end_done[i] = !active[i] ||
                          ((ended_reg[i] || (in_idx == LANE_W'(i))) && !cnt_nz[i]);
            pop_done[i] = !active[i] ||
                          (ended_reg[i] && (!cnt_nz[i] ||
                           ((best_lane_reg == LANE_W'(i)) && (cnt_reg[i] == CNT_W'(1)))));
        end
    end

    assign all_ready     = &(~active | cnt_nz | ended_reg);
    assign any_head      = |(active & cnt_nz);
    assign pop_completes = &pop_done;

    // Classify the incoming request
    assign end_ok   = (in_kind == KIND_END) && in_act && !ended_reg[in_idx];
    assign value_ok = (in_kind == KIND_VALUE) && in_act && !ended_reg[in_idx] &&
                      (cnt_reg[in_idx] != CNT_W'(LANE_DEPTH));

    always_comb
    begin
        status.drop            = (in_kind == KIND_VALUE) && !value_ok;
        status.complete_on_end = end_ok && (&end_done);
        status.can_emit        = all_ready && any_head;
        status.scan_last       = (scan_idx_reg == LANE_W'(n_reg - NUM_W'(1)));
        status.out_free        = !out_valid_reg || results.ready;
    end

    assign clear_all = cmd.accept_cfg || (cmd.accept_in && status.complete_on_end) ||
                       (cmd.emit && pop_completes);

    // Effective lane count from the register value
    always_comb
    begin
        if (CFG_CMP_W'(cfg_data) == '0)
            n_next = NUM_W'(1);
        else if (CFG_CMP_W'(cfg_data) > CFG_CMP_W'(LANES))
            n_next = NUM_W'(LANES);
        else
            n_next = NUM_W'(cfg_data);
    end

    // Tail slot of the target lane, wrapped at the queue depth
    always_comb
    begin
        wr_sum = SUM_W'(rd_reg[in_idx]) + SUM_W'(cnt_reg[in_idx]);
        if (wr_sum >= SUM_W'(LANE_DEPTH))
            wr_sum = wr_sum - SUM_W'(LANE_DEPTH);
        wr_slot = wr_sum[SLOT_W-1:0];
    end

    assign wr_addr = ADDR_W'(in_idx) * ADDR_W'(LANE_DEPTH) + ADDR_W'(wr_slot);
    assign rd_addr = ADDR_W'(scan_idx_reg) * ADDR_W'(LANE_DEPTH) +
                     ADDR_W'(rd_reg[scan_idx_reg]);
    assign wr_en   = cmd.accept_in && value_ok;

    // Store values and read heads
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= in_value;
        rd_data_reg <= store_mem[rd_addr];
    end

    // Update lane counts, head slots and end flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= NUM_W'(N_RESET);
            ended_reg <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                cnt_reg[i] <= '0;
                rd_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.accept_cfg)
                n_reg <= n_next;
            if (clear_all)
            begin
                ended_reg <= '0;
                for (int i = 0; i < LANES; i++)
                begin
                    cnt_reg[i] <= '0;
                    rd_reg[i]  <= '0;
                end
            end
            else
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (wr_en && (in_idx == LANE_W'(i)))
                        cnt_reg[i] <= cnt_reg[i] + CNT_W'(1);
                    if (cmd.accept_in && end_ok && (in_idx == LANE_W'(i)))
                        ended_reg[i] <= 1'b1;
                    if (cmd.emit && (best_lane_reg == LANE_W'(i)))
                    begin
                        cnt_reg[i] <= cnt_reg[i] - CNT_W'(1);
                        if (rd_reg[i] == SLOT_W'(LANE_DEPTH - 1))
                            rd_reg[i] <= '0;
                        else
                            rd_reg[i] <= rd_reg[i] + SLOT_W'(1);
                    end
                end
            end
        end
    end

    // Walk the lanes and keep the smallest head, lowest lane on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            tag_valid_reg <= 1'b0;
            best_any_reg  <= 1'b0;
        end
        else
        begin
            tag_valid_reg <= cmd.scan_step && cnt_nz[scan_idx_reg];
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                best_any_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                    scan_idx_reg <= scan_idx_reg + LANE_W'(1);
                if (tag_valid_reg && (!best_any_reg || (rd_data_reg < best_val_reg)))
                    best_any_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_lane_reg <= scan_idx_reg;
        if (!cmd.scan_start && tag_valid_reg &&
            (!best_any_reg || (rd_data_reg < best_val_reg)))
        begin
            best_lane_reg <= tag_lane_reg;
            best_val_reg  <= rd_data_reg;
        end
    end

    // Hold the marker for a refused value or a finished set
    always_ff @(posedge clk)
    begin
        if (cmd.accept_in)
        begin
            pend_drop_reg <= status.drop;
            pend_lane_reg <= in_lane;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit || cmd.mark)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_value_reg <= best_val_reg;
            out_lane_reg  <= LANE_FW'(best_lane_reg);
            out_has_reg   <= 1'b1;
            out_last_reg  <= pop_completes;
            out_drop_reg  <= 1'b0;
        end
        else if (cmd.mark)
        begin
            out_value_reg <= '0;
            out_lane_reg  <= pend_drop_reg ? pend_lane_reg : '0;
            out_has_reg   <= 1'b0;
            out_last_reg  <= !pend_drop_reg;
            out_drop_reg  <= pend_drop_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.merged_value = out_value_reg;
    assign results.source_lane  = out_lane_reg;
    assign results.has_value    = out_has_reg;
    assign results.last         = out_last_reg;
    assign results.dropped      = out_drop_reg;

    // Checks
    a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> best_any_reg)
        else $error("emit without a selected head");

    a_emit_lane_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> cnt_nz[best_lane_reg])
        else $error("emit from an empty lane");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.mark) |-> status.out_free)
        else $error("output register overwritten");

    a_clear_after_set: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && pop_completes) |=> ((cnt_nz == '0) && (ended_reg == '0)))
        else $error("lanes not cleared after final result");

endmodule

`default_nettype wire

// ===== rtl/core/k_way_sorted_merge_unit.sv =====
// K-way merge of sorted lanes into one ascending result stream.
// Channels: items (sink) carries a value or an end mark for one lane; results
// (source) carries merged values, drop markers and the completion marker; cfg
// (sink) writes lanes_in_use, which also clears all lanes. All channels move a
// request when valid and ready are high at a rising edge of clk.
// Flow: a request is taken while the unit is idle. Each emitted value then
// passes a check state, a scan of the n lanes in use with one lane head read
// per cycle from the lane store, a drain state for the read register and an
// emit state that loads the output register. A drop or completion marker
// goes through a mark state into the output register; a request that
// releases no value returns the unit to idle through the check state.
// The output register lets a new request be taken while a result waits; while
// the receiver stalls, the unit holds before loading the next result.
// Reset (rst_n, asynchronous, active low) empties all lanes, clears end flags,
// empties the output register and sets lanes_in_use to 8 (capped at LANES).
// Lane store contents are not cleared; queue counts guard every read.
`default_nettype none

module k_way_sorted_merge_unit #(
    parameter int LANES      = kwm_pkg::LANES_DEF,
    parameter int LANE_DEPTH = kwm_pkg::LANE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    kwm_cfg_if.sink   cfg,
    kwm_in_if.sink    items,
    kwm_out_if.source results
);
    import kwm_pkg::*;

    kwm_cmd_t    cmd;
    kwm_status_t status;
    logic        in_ready;
    logic        cfg_ready;

    assign items.ready = in_ready;
    assign cfg.ready   = cfg_ready;

    kwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .cfg_valid (cfg.valid),
        .status    (status),
        .in_ready  (in_ready),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    kwm_datapath #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg_data (cfg.lanes_in_use),
        .in_kind  (items.kind),
        .in_lane  (items.lane),
        .in_value (items.value),
        .results  (results)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import kwm_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int SEQ_MAX       = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic [LANE_FW-1:0]        source_lane;
        logic                      has_value;
        logic                      last;
        logic                      dropped;
    } merge_result_t;

    // Lane queues, end flags and the merge order, tracked per request
    class merge_scoreboard;
        logic signed [VALUE_W-1:0] lane_data [LANES_DEF][LANE_DEPTH_DEF];
        int unsigned               fill [LANES_DEF];
        int unsigned               rd_slot [LANES_DEF];
        bit                        ended [LANES_DEF];
        logic [CFG_W-1:0]          lanes_reg;
        merge_result_t             pending [$];
        int                        errors;
        int                        checked;
        int                        drops;
        int                        sets_done;

        function new();
            lanes_reg = CFG_W'(CFG_RESET);
            errors    = 0;
            checked   = 0;
            drops     = 0;
            sets_done = 0;
            clear_lanes();
        endfunction

        function void clear_lanes();
            for (int i = 0; i < LANES_DEF; i++)
            begin
                fill[i]    = 0;
                rd_slot[i] = 0;
                ended[i]   = 1'b0;
            end
        endfunction

        // Clamp the register: zero acts as one lane, overflow as all lanes
        function int active_count();
            int n;
            n = int'(lanes_reg);
            if (n == 0)
                n = 1;
            if (n > LANES_DEF)
                n = LANES_DEF;
            return n;
        endfunction

        function void configure(logic [CFG_W-1:0] v);
            lanes_reg = v;
            clear_lanes();
        endfunction

        function bit set_done(int n);
            for (int i = 0; i < n; i++)
                if (!ended[i] || fill[i] != 0)
                    return 1'b0;
            return 1'b1;
        endfunction

        function void queue_result(logic signed [VALUE_W-1:0] v, int lane, bit has,
                                   bit fin, bit drop);
            merge_result_t r;
            r.merged_value = v;
            r.source_lane  = lane[LANE_FW-1:0];
            r.has_value    = has;
            r.last         = fin;
            r.dropped      = drop;
            pending.push_back(r);
        endfunction

        // Apply one accepted request; return 0 when the block ignores it
        function bit note_request(logic kind, logic [LANE_FW-1:0] lane,
                                  logic signed [VALUE_W-1:0] value);
            int                        n;
            int                        best;
            bit                        any;
            bit                        waiting;
            bit                        fin;
            logic signed [VALUE_W-1:0] best_val;
            n = active_count();
            if (kind == KIND_VALUE)
            begin
                // Refuse values for unused, ended or full lanes
                if (lane >= n || ended[lane] || fill[lane] >= LANE_DEPTH_DEF)
                begin
                    queue_result('0, int'(lane), 1'b0, 1'b0, 1'b1);
                    return 1'b1;
                end
                lane_data[lane][(rd_slot[lane] + fill[lane]) % LANE_DEPTH_DEF] = value;
                fill[lane]++;
            end
            else
            begin
                if (lane >= n || ended[lane])
                    return 1'b0;
                ended[lane] = 1'b1;
                if (set_done(n))
                begin
                    queue_result('0, 0, 1'b0, 1'b1, 1'b0);
                    clear_lanes();
                    return 1'b1;
                end
            end
            // Release heads while every open lane holds a value
            while (1)
            begin
                any      = 1'b0;
                waiting  = 1'b0;
                best     = 0;
                best_val = '0;
                for (int i = 0; i < n; i++)
                begin
                    if (fill[i] == 0)
                    begin
                        if (!ended[i])
                            waiting = 1'b1;
                    end
                    else if (!any || lane_data[i][rd_slot[i]] < best_val)
                    begin
                        best     = i;
                        best_val = lane_data[i][rd_slot[i]];
                        any      = 1'b1;
                    end
                end
                if (waiting || !any)
                    break;
                rd_slot[best] = (rd_slot[best] + 1) % LANE_DEPTH_DEF;
                fill[best]--;
                fin = set_done(n);
                queue_result(best_val, best, 1'b1, fin, 1'b0);
                if (fin)
                begin
                    clear_lanes();
                    break;
                end
            end
            return 1'b1;
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(merge_result_t got);
            merge_result_t exp;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result value=%0d lane=%0d has=%0b",
                         $time, got.merged_value, got.source_lane, got.has_value,
                         " last=%0b drop=%0b", got.last, got.dropped);
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (exp.dropped)
                drops++;
            if (exp.last)
                sets_done++;
            if (got !== exp)
            begin
                errors++;
                $display("%0t: mismatch expected value=%0d lane=%0d has=%0b last=%0b drop=%0b,",
                         $time, exp.merged_value, exp.source_lane, exp.has_value,
                         exp.last, exp.dropped,
                         " got value=%0d lane=%0d has=%0b last=%0b drop=%0b",
                         got.merged_value, got.source_lane, got.has_value,
                         got.last, got.dropped);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    kwm_cfg_if cfg();
    kwm_in_if  items();
    kwm_out_if results();

    k_way_sorted_merge_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .items   (items),
        .results (results)
    );

    merge_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int taken_count;
    int settings_used;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: check accepted results, then pick ready for the next cycle
    initial
    begin
        merge_result_t got;
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results.valid && results.ready)
            begin
                got.merged_value = results.merged_value;
                got.source_lane  = results.source_lane;
                got.has_value    = results.has_value;
                got.last         = results.last;
                got.dropped      = results.dropped;
                sb.check_result(got);
            end
            if (hold_cycles > 0)
            begin
                results.ready <= 1'b0;
                hold_cycles--;
            end
            else
                results.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return $signed($urandom_range(8)) - 4;
            1: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                        : 32'sh80000000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input logic kind, input logic [LANE_FW-1:0] lane,
                                input logic signed [VALUE_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            items.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        items.valid <= 1'b1;
        items.kind  <= kind;
        items.lane  <= lane;
        items.value <= value;
        do
            @(posedge clk);
        while (!items.ready);
        if (sb.note_request(kind, lane, value))
            taken_count++;
    endtask

    // Stop offering, wait for every outstanding result, then let the block settle
    task automatic drain();
        items.valid <= 1'b0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_lanes(input logic [CFG_W-1:0] v);
        cfg.valid        <= 1'b1;
        cfg.lanes_in_use <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.configure(v);
        cfg.valid <= 1'b0;
        settings_used++;
    endtask

    // Sorted sets interleaved across lanes, with some noise mixed in
    task automatic run_sets(input int budget);
        int                        n;
        int                        start;
        int                        pick;
        int                        open_lanes;
        int                        tmp [$];
        logic signed [VALUE_W-1:0] seq [LANES_DEF][SEQ_MAX];
        int                        len [LANES_DEF];
        int                        pos [LANES_DEF];
        bit                        closed [LANES_DEF];
        start = taken_count;
        while (taken_count - start < budget)
        begin
            n = sb.active_count();
            for (int i = 0; i < n; i++)
            begin
                tmp.delete();
                repeat ($urandom_range(SEQ_MAX)) tmp.push_back(rand_value());
                tmp.sort();
                len[i]    = tmp.size();
                pos[i]    = 0;
                closed[i] = 1'b0;
                for (int j = 0; j < len[i]; j++)
                    seq[i][j] = tmp[j];
            end
            open_lanes = n;
            while (open_lanes > 0)
            begin
                if ($urandom_range(9) == 0)
                    send_request($urandom_range(3) == 0 ? KIND_END : KIND_VALUE,
                                 LANE_FW'($urandom_range(LANES_DEF - 1)), $urandom);
                else
                begin
                    pick = $urandom_range(n - 1);
                    while (closed[pick])
                        pick = (pick + 1) % n;
                    if (pos[pick] < len[pick])
                    begin
                        send_request(KIND_VALUE, LANE_FW'(pick), seq[pick][pos[pick]]);
                        pos[pick]++;
                    end
                    else
                    begin
                        send_request(KIND_END, LANE_FW'(pick), $urandom);
                        closed[pick] = 1'b1;
                        open_lanes--;
                    end
                end
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] settings [6];
        settings      = '{4'd0, 4'd15, 4'd5, 4'd1, 4'd8, 4'd2};
        send_idle_pct = 25;
        recv_idle_pct = 50;
        hold_cycles   = 0;
        taken_count   = 0;
        settings_used = 0;
        rst_n            <= 1'b0;
        items.valid      <= 1'b0;
        items.kind       <= KIND_VALUE;
        items.lane       <= '0;
        items.value      <= '0;
        cfg.valid        <= 1'b0;
        cfg.lanes_in_use <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, ties, refusals, ignored end marks, both completions
        write_lanes(4'd3);
        send_request(KIND_VALUE, 3'd0, 32'sh80000000);
        send_request(KIND_VALUE, 3'd1, 32'sh7fffffff);
        send_request(KIND_VALUE, 3'd2, 0);
        send_request(KIND_VALUE, 3'd0, 0);
        send_request(KIND_VALUE, 3'd5, 5);
        send_request(KIND_END, 3'd6, 0);
        send_request(KIND_END, 3'd0, 0);
        send_request(KIND_END, 3'd0, 0);
        send_request(KIND_VALUE, 3'd0, 7);
        send_request(KIND_VALUE, 3'd2, -1);
        repeat (8) send_request(KIND_VALUE, 3'd1, 32'sh7fffffff);
        send_request(KIND_END, 3'd2, 0);
        send_request(KIND_END, 3'd0, 0);
        send_request(KIND_END, 3'd1, 0);
        send_request(KIND_END, 3'd2, 0);
        // Leave a set open so the next register write aborts it
        send_request(KIND_VALUE, 3'd0, 42);
        drain();

        // Random sets across lane settings and idle patterns
        for (int p = 0; p < 7; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 50;
            end
            else if (p < 4)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_lanes(p < 6 ? settings[p] : 4'($urandom_range(15)));
            if (p == 1)
                hold_cycles = 300;
            if (p == 3)
            begin
                run_sets(34);
                drain();
            end
            run_sets(34);
            drain();
        end

        $display("Merged %0d requests under %0d lane settings: %0d results checked,",
                 taken_count, settings_used, sb.checked);
        $display("%0d refused values, %0d sets completed, %0d errors",
                 sb.drops, sb.sets_done, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
